@@ sv/obpa_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// obpa_pkg: shared definitions for the oscillometric blood-pressure analyzer
// Sizes, codes, controller/datapath interface types and the category function.
// -----------------------------------------------------------------------------
package obpa_pkg;

	// Record geometry and analysis windows
	localparam int RECORD_DEPTH     = 2048;
	localparam int SYSTOLIC_SCAN    = 1024;
	localparam int RISE_WINDOW      = 20;
	localparam int BEAT_HALF_WINDOW = 37;

	localparam int ADDR_W = $clog2(RECORD_DEPTH);
	localparam int LEN_W  = $clog2(RECORD_DEPTH + 1);
	localparam int K_W    = $clog2(RISE_WINDOW + 1);
	localparam int BEAT_W = $clog2(2 * BEAT_HALF_WINDOW + 2);
	localparam int SUM_W  = LEN_W + 15;

	// Field widths
	localparam int COUNT_W    = 24;
	localparam int P_W        = 15;
	localparam int SLOPE_W    = 16;
	localparam int RATE_W     = 2;
	localparam int SYS_W      = 15;
	localparam int DIA_W      = 16;
	localparam int DIA_FULL_W = 18;
	localparam int HR_W       = 9;
	localparam int CAT_W      = 3;
	localparam int MINR_W     = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	// Sensor transfer function: (count * gain - offset) >> 24
	localparam int PROD_W = 41;
	localparam logic [PROD_W-1:0] CONV_GAIN   = PROD_W'(64'd96000);
	localparam logic [PROD_W-1:0] CONV_OFFSET = PROD_W'(64'd40265318400);
	localparam logic [P_W-1:0]    P_MAX       = 15'd32767;

	// Deflation rate codes
	localparam logic [RATE_W-1:0] RATE_STEADY = 2'd0;
	localparam logic [RATE_W-1:0] RATE_FAST   = 2'd1;
	localparam logic [RATE_W-1:0] RATE_SLOW   = 2'd2;

	// Category codes
	localparam logic [CAT_W-1:0] CAT_NORMAL   = 3'd0;
	localparam logic [CAT_W-1:0] CAT_ELEVATED = 3'd1;
	localparam logic [CAT_W-1:0] CAT_STAGE1   = 3'd2;
	localparam logic [CAT_W-1:0] CAT_STAGE2   = 3'd3;
	localparam logic [CAT_W-1:0] CAT_STAGE3   = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STOP_LEVEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_DROP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_DROP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RISES  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HIGH   = 3'd5;

	// Datapath operations
	typedef logic [4:0] op_t;
	localparam op_t OP_NONE      = 5'd0;
	localparam op_t OP_LOAD      = 5'd1;
	localparam op_t OP_MUL       = 5'd2;
	localparam op_t OP_CONV      = 5'd3;
	localparam op_t OP_STEP      = 5'd4;
	localparam op_t OP_SYS_INIT  = 5'd5;
	localparam op_t OP_ADDR_I    = 5'd6;
	localparam op_t OP_SYS_USE   = 5'd7;
	localparam op_t OP_ADDR_WIN  = 5'd8;
	localparam op_t OP_WIN_USE   = 5'd9;
	localparam op_t OP_WIN_END   = 5'd10;
	localparam op_t OP_MS_INIT   = 5'd11;
	localparam op_t OP_MS_USE    = 5'd12;
	localparam op_t OP_MV_INIT   = 5'd13;
	localparam op_t OP_MV_USE    = 5'd14;
	localparam op_t OP_ADDR_J    = 5'd15;
	localparam op_t OP_SUM_USE   = 5'd16;
	localparam op_t OP_SUM_END   = 5'd17;
	localparam op_t OP_ADDR_BIDX = 5'd18;
	localparam op_t OP_MAP_TAKE  = 5'd19;
	localparam op_t OP_BT_INIT   = 5'd20;
	localparam op_t OP_BT_USE    = 5'd21;
	localparam op_t OP_CAT       = 5'd22;
	localparam op_t OP_EMIT      = 5'd23;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic analyze;
		logic i_ge_scan;
		logic i_ge_len;
		logic j_ge_len;
		logic k_end;
		logic i_gt_end;
		logic s_pos;
		logic s_neg;
		logic p_gt_high;
		logic p_gt_low;
		logic cnt_ok;
		logic map_err;
	} status_t;

	// Thresholds in 1/64 mmHg
	localparam logic signed [DIA_FULL_W-1:0] MMHG_80  = 18'sd5120;
	localparam logic signed [DIA_FULL_W-1:0] MMHG_90  = 18'sd5760;
	localparam logic signed [DIA_FULL_W-1:0] MMHG_120 = 18'sd7680;
	localparam logic signed [DIA_FULL_W-1:0] MMHG_130 = 18'sd8320;
	localparam logic signed [DIA_FULL_W-1:0] MMHG_140 = 18'sd8960;
	localparam logic signed [DIA_FULL_W-1:0] MMHG_180 = 18'sd11520;

	// Hypertension category from systolic and unsaturated diastolic
	function automatic logic [CAT_W-1:0] classify(input logic [SYS_W-1:0] sys,
		input logic signed [DIA_FULL_W-1:0] dia);
		logic signed [DIA_FULL_W-1:0] s;
		logic [CAT_W-1:0] c;
		s = $signed({3'b000, sys});
		if (s < MMHG_120 && dia < MMHG_80)
			c = CAT_NORMAL;
		else if (s >= MMHG_120 && s < MMHG_130 && dia < MMHG_80)
			c = CAT_ELEVATED;
		else if ((s >= MMHG_130 && s < MMHG_140) || (dia >= MMHG_80 && dia < MMHG_90))
			c = CAT_STAGE1;
		else if ((s >= MMHG_140 && s < MMHG_180) || (dia >= MMHG_90 && dia < MMHG_120))
			c = CAT_STAGE2;
		else
			c = CAT_STAGE3;
		return c;
	endfunction

endpackage

@@ sv/obpa_ifs.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// obpa channel interfaces
// Valid/ready channels for sensor samples and analysis results.
// -----------------------------------------------------------------------------
interface obpa_sample_if;
	logic                             valid;
	logic                             ready;
	logic                             action;
	logic [obpa_pkg::COUNT_W-1:0]     sensor_count;

	modport source (output valid, output action, output sensor_count, input ready);
	modport sink   (input valid, input action, input sensor_count, output ready);
endinterface

interface obpa_result_if;
	logic                               valid;
	logic                               ready;
	logic [obpa_pkg::P_W-1:0]           pressure;
	logic [obpa_pkg::RATE_W-1:0]        rate_status;
	logic                               done_res;
	logic [obpa_pkg::SYS_W-1:0]         systolic;
	logic signed [obpa_pkg::DIA_W-1:0]  diastolic;
	logic [obpa_pkg::HR_W-1:0]          heart_rate;
	logic [obpa_pkg::CAT_W-1:0]         category;
	logic                               deflate_error;

	modport source (output valid, output pressure, output rate_status, output done_res,
		output systolic, output diastolic, output heart_rate, output category,
		output deflate_error, input ready);
	modport sink (input valid, input pressure, input rate_status, input done_res,
		input systolic, input diastolic, input heart_rate, input category,
		input deflate_error, output ready);
endinterface

@@ sv/obpa_dp.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// obpa_dp: analyzer datapath
// Conversion, record memories, search registers and result registers.
// -----------------------------------------------------------------------------
module obpa_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  obpa_pkg::cmd_t                      cmd,
	output obpa_pkg::status_t                   st,
	input  logic                                wr_en,
	input  logic [obpa_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [obpa_pkg::CFG_DATA_W-1:0]     wr_data,
	input  logic                                action,
	input  logic [obpa_pkg::COUNT_W-1:0]        sensor_count,
	output logic [obpa_pkg::P_W-1:0]            pressure,
	output logic [obpa_pkg::RATE_W-1:0]         rate_status,
	output logic                                done_res,
	output logic [obpa_pkg::SYS_W-1:0]          systolic,
	output logic signed [obpa_pkg::DIA_W-1:0]   diastolic,
	output logic [obpa_pkg::HR_W-1:0]           heart_rate,
	output logic [obpa_pkg::CAT_W-1:0]          category,
	output logic                                deflate_error
);

	// Configuration registers
	logic [obpa_pkg::P_W-1:0]    stop_q, fast_q, slow_q, low_q, high_q;
	logic [obpa_pkg::MINR_W-1:0] minr_q;

	// Record control
	logic [obpa_pkg::P_W-1:0]   last_q;
	logic [obpa_pkg::LEN_W-1:0] len_q;
	logic                       rec_q;

	// Sample path
	logic                             action_q;
	logic [obpa_pkg::COUNT_W-1:0]     count_q;
	logic [obpa_pkg::PROD_W-1:0]      prod_q;
	logic [obpa_pkg::P_W-1:0]         p_q;

	// Record memories
	logic [obpa_pkg::P_W-1:0]           pmem [obpa_pkg::RECORD_DEPTH];
	logic signed [obpa_pkg::SLOPE_W-1:0] smem [obpa_pkg::RECORD_DEPTH];
	logic [obpa_pkg::P_W-1:0]           rp_q;
	logic signed [obpa_pkg::SLOPE_W-1:0] rs_q;
	logic [obpa_pkg::ADDR_W-1:0]        addr_q;
	logic                               mem_we;

	// Search registers
	logic [obpa_pkg::LEN_W-1:0]  i_q, j_q, start_q, end_q;
	logic [obpa_pkg::K_W-1:0]    k_q, cnt_q;
	logic [obpa_pkg::P_W-1:0]    pcand_q;
	logic [obpa_pkg::SYS_W-1:0]  sys_q;
	logic [obpa_pkg::SUM_W-1:0]  sum_q, best_q;
	logic [obpa_pkg::ADDR_W-1:0] bidx_q, mi_q;
	logic [obpa_pkg::BEAT_W-1:0] beat_q;
	logic                        prevpos_q;
	logic signed [obpa_pkg::DIA_FULL_W-1:0] dia_q;

	// Result being built and result on offer
	logic [obpa_pkg::P_W-1:0]          res_p_q;
	logic [obpa_pkg::RATE_W-1:0]       res_rate_q;
	logic                              res_done_q;
	logic [obpa_pkg::SYS_W-1:0]        res_sys_q;
	logic signed [obpa_pkg::DIA_W-1:0] res_dia_q;
	logic [obpa_pkg::HR_W-1:0]         res_hr_q;
	logic [obpa_pkg::CAT_W-1:0]        res_cat_q;
	logic                              res_err_q;

	// Combinational helpers
	logic [obpa_pkg::PROD_W-1:0]         conv_diff;
	logic [obpa_pkg::PROD_W-25:0]        conv_v;
	logic [obpa_pkg::P_W-1:0]            conv_p;
	logic signed [obpa_pkg::SLOPE_W-1:0] slope_d;
	logic signed [obpa_pkg::SLOPE_W:0]   d17, neg_fast, neg_slow;
	logic [obpa_pkg::RATE_W-1:0]         rate_code;
	logic                                rec_step;
	logic [obpa_pkg::LEN_W-1:0]          last_idx;
	logic [obpa_pkg::LEN_W:0]            win_pos;
	logic [obpa_pkg::ADDR_W-1:0]         win_addr;
	logic [15:0]                         mi16, bt_lo, bt_hi, lastw, bt_end;
	logic signed [obpa_pkg::DIA_FULL_W-1:0] dia_full;
	logic signed [obpa_pkg::DIA_W-1:0]   dia_sat;
	logic [15:0]                         hr4;

	// Convert the product to pressure, saturated
	always_comb begin
		conv_diff = prod_q - obpa_pkg::CONV_OFFSET;
		conv_v    = conv_diff[obpa_pkg::PROD_W-1:24];
		if (prod_q <= obpa_pkg::CONV_OFFSET)
			conv_p = '0;
		else if (conv_v > (obpa_pkg::PROD_W-24)'(obpa_pkg::P_MAX))
			conv_p = obpa_pkg::P_MAX;
		else
			conv_p = conv_v[obpa_pkg::P_W-1:0];
	end

	// Slope and deflation class
	always_comb begin
		slope_d  = $signed({1'b0, p_q}) - $signed({1'b0, last_q});
		d17      = {slope_d[obpa_pkg::SLOPE_W-1], slope_d};
		neg_fast = -$signed({2'b00, fast_q});
		neg_slow = -$signed({2'b00, slow_q});
		if (d17 < neg_fast)
			rate_code = obpa_pkg::RATE_FAST;
		else if (d17 > neg_slow && d17 < 0)
			rate_code = obpa_pkg::RATE_SLOW;
		else
			rate_code = obpa_pkg::RATE_STEADY;
	end

	assign rec_step = action_q & rec_q;
	assign mem_we   = (cmd.op == obpa_pkg::OP_STEP) & rec_step;
	assign last_idx = len_q - 1'b1;

	// Rise window address, clamped to the last entry
	always_comb begin
		win_pos = {1'b0, i_q} + (obpa_pkg::LEN_W+1)'(k_q);
		if (win_pos > {1'b0, last_idx})
			win_addr = last_idx[obpa_pkg::ADDR_W-1:0];
		else
			win_addr = win_pos[obpa_pkg::ADDR_W-1:0];
	end

	// Beat window bounds around the MAP index
	always_comb begin
		mi16   = 16'(mi_q);
		lastw  = 16'(len_q) - 16'd1;
		bt_hi  = mi16 + 16'(obpa_pkg::BEAT_HALF_WINDOW + 1);
		bt_lo  = (mi16 >= 16'(obpa_pkg::BEAT_HALF_WINDOW)) ?
			mi16 - 16'(obpa_pkg::BEAT_HALF_WINDOW) : 16'd0;
		bt_end = (bt_hi > lastw) ? lastw : bt_hi;
	end

	// Diastolic from MAP read data and systolic
	always_comb begin
		dia_full = $signed({2'b00, rp_q, 1'b0}) - $signed({3'b000, sys_q});
		if (dia_full > 18'sd32767)
			dia_sat = 16'sh7FFF;
		else
			dia_sat = dia_full[obpa_pkg::DIA_W-1:0];
		hr4 = 16'({beat_q, 2'b00});
	end

	// Status to the controller
	always_comb begin
		st.analyze   = rec_step & ((p_q <= stop_q) |
			(len_q == obpa_pkg::LEN_W'(obpa_pkg::RECORD_DEPTH - 1)));
		st.i_ge_len  = i_q >= len_q;
		st.i_ge_scan = (i_q >= len_q) | (32'(i_q) >= 32'(obpa_pkg::SYSTOLIC_SCAN));
		st.j_ge_len  = j_q >= len_q;
		st.k_end     = k_q == obpa_pkg::K_W'(obpa_pkg::RISE_WINDOW);
		st.i_gt_end  = i_q > end_q;
		st.s_pos     = rs_q > 0;
		st.s_neg     = rs_q < 0;
		st.p_gt_high = rp_q > high_q;
		st.p_gt_low  = rp_q > low_q;
		st.cnt_ok    = 32'(cnt_q) > 32'(minr_q);
		st.map_err   = (rp_q > high_q) | (rp_q < low_q);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= 15'd1920;
			fast_q <= 15'd51;
			slow_q <= 15'd13;
			minr_q <= 6'd4;
			low_q  <= 15'd5120;
			high_q <= 15'd8320;
		end else if (wr_en) begin
			unique case (wr_index)
				obpa_pkg::REG_STOP_LEVEL: stop_q <= wr_data;
				obpa_pkg::REG_FAST_DROP:  fast_q <= wr_data;
				obpa_pkg::REG_SLOW_DROP:  slow_q <= wr_data;
				obpa_pkg::REG_MIN_RISES:  minr_q <= wr_data[obpa_pkg::MINR_W-1:0];
				obpa_pkg::REG_MAP_LOW:    low_q  <= wr_data;
				obpa_pkg::REG_MAP_HIGH:   high_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Record control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			len_q  <= '0;
			rec_q  <= 1'b0;
		end else if (cmd.op == obpa_pkg::OP_STEP) begin
			if (!action_q) begin
				last_q <= p_q;
				len_q  <= '0;
				rec_q  <= 1'b1;
			end else if (rec_q) begin
				last_q <= p_q;
				len_q  <= len_q + 1'b1;
				if (st.analyze)
					rec_q <= 1'b0;
			end
		end
	end

	// Record memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pmem[len_q[obpa_pkg::ADDR_W-1:0]] <= p_q;
			smem[len_q[obpa_pkg::ADDR_W-1:0]] <= slope_d;
		end
		rp_q <= pmem[addr_q];
		rs_q <= smem[addr_q];
	end

	// Work registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			obpa_pkg::OP_LOAD: begin
				action_q <= action;
				count_q  <= sensor_count;
			end
			obpa_pkg::OP_MUL: begin
				prod_q <= obpa_pkg::PROD_W'(count_q) * obpa_pkg::CONV_GAIN;
			end
			obpa_pkg::OP_CONV: begin
				p_q <= conv_p;
			end
			obpa_pkg::OP_STEP: begin
				res_p_q    <= p_q;
				res_rate_q <= rec_step ? rate_code : obpa_pkg::RATE_STEADY;
				res_done_q <= st.analyze;
				res_sys_q  <= '0;
				res_dia_q  <= '0;
				res_hr_q   <= '0;
				res_cat_q  <= obpa_pkg::CAT_NORMAL;
				res_err_q  <= 1'b0;
			end
			obpa_pkg::OP_SYS_INIT: begin
				i_q   <= '0;
				sys_q <= '0;
			end
			obpa_pkg::OP_ADDR_I: begin
				addr_q <= i_q[obpa_pkg::ADDR_W-1:0];
			end
			obpa_pkg::OP_SYS_USE: begin
				pcand_q <= rp_q;
				k_q     <= '0;
				cnt_q   <= '0;
				if (!st.s_pos)
					i_q <= i_q + 1'b1;
			end
			obpa_pkg::OP_ADDR_WIN: begin
				addr_q <= win_addr;
			end
			obpa_pkg::OP_WIN_USE: begin
				if (st.s_pos)
					cnt_q <= cnt_q + 1'b1;
				k_q <= k_q + 1'b1;
			end
			obpa_pkg::OP_WIN_END: begin
				if (st.cnt_ok)
					sys_q <= pcand_q;
				else
					i_q <= i_q + 1'b1;
			end
			obpa_pkg::OP_MS_INIT: begin
				i_q     <= obpa_pkg::LEN_W'(1);
				start_q <= '0;
			end
			obpa_pkg::OP_MS_USE: begin
				if (st.p_gt_high) begin
					start_q <= i_q;
					i_q     <= i_q + 1'b1;
				end
			end
			obpa_pkg::OP_MV_INIT: begin
				i_q    <= start_q;
				best_q <= '0;
				bidx_q <= '0;
			end
			obpa_pkg::OP_MV_USE: begin
				j_q   <= i_q + 1'b1;
				sum_q <= '0;
				if (!st.s_pos)
					i_q <= i_q + 1'b1;
			end
			obpa_pkg::OP_ADDR_J: begin
				addr_q <= j_q[obpa_pkg::ADDR_W-1:0];
			end
			obpa_pkg::OP_SUM_USE: begin
				if (!st.s_neg) begin
					sum_q <= sum_q + obpa_pkg::SUM_W'(rs_q[obpa_pkg::SLOPE_W-2:0]);
					j_q   <= j_q + 1'b1;
				end
			end
			obpa_pkg::OP_SUM_END: begin
				if (sum_q > best_q) begin
					best_q <= sum_q;
					bidx_q <= (j_q < len_q) ? j_q[obpa_pkg::ADDR_W-1:0] :
						last_idx[obpa_pkg::ADDR_W-1:0];
				end
				i_q <= i_q + 1'b1;
			end
			obpa_pkg::OP_ADDR_BIDX: begin
				addr_q <= bidx_q;
				mi_q   <= bidx_q;
			end
			obpa_pkg::OP_MAP_TAKE: begin
				dia_q <= dia_full;
				if (st.map_err) begin
					res_err_q <= 1'b1;
				end else begin
					res_sys_q <= sys_q;
					res_dia_q <= dia_sat;
				end
			end
			obpa_pkg::OP_BT_INIT: begin
				i_q       <= bt_lo[obpa_pkg::LEN_W-1:0];
				end_q     <= bt_end[obpa_pkg::LEN_W-1:0];
				beat_q    <= '0;
				prevpos_q <= 1'b0;
			end
			obpa_pkg::OP_BT_USE: begin
				if (prevpos_q && st.s_neg)
					beat_q <= beat_q + 1'b1;
				prevpos_q <= st.s_pos;
				i_q       <= i_q + 1'b1;
			end
			obpa_pkg::OP_CAT: begin
				res_hr_q  <= (hr4 > 16'd511) ? 9'd511 : hr4[obpa_pkg::HR_W-1:0];
				res_cat_q <= obpa_pkg::classify(sys_q, dia_q);
			end
			obpa_pkg::OP_EMIT: begin
				pressure      <= res_p_q;
				rate_status   <= res_rate_q;
				done_res      <= res_done_q;
				systolic      <= res_sys_q;
				diastolic     <= res_dia_q;
				heart_rate    <= res_hr_q;
				category      <= res_cat_q;
				deflate_error <= res_err_q;
			end
			default: ;
		endcase
	end

endmodule

@@ sv/obpa_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// obpa_ctrl: analyzer sequencer
// Steps each sample through conversion and recording, walks ended records.
// -----------------------------------------------------------------------------
module obpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  obpa_pkg::status_t st,
	output obpa_pkg::cmd_t    cmd
);

	localparam logic [5:0] S_IDLE     = 6'd0;
	localparam logic [5:0] S_MUL      = 6'd1;
	localparam logic [5:0] S_CONV     = 6'd2;
	localparam logic [5:0] S_STEP     = 6'd3;
	localparam logic [5:0] S_SYS_INIT = 6'd4;
	localparam logic [5:0] S_SYS_CHK  = 6'd5;
	localparam logic [5:0] S_SYS_RD   = 6'd6;
	localparam logic [5:0] S_SYS_USE  = 6'd7;
	localparam logic [5:0] S_WIN_ADDR = 6'd8;
	localparam logic [5:0] S_WIN_RD   = 6'd9;
	localparam logic [5:0] S_WIN_USE  = 6'd10;
	localparam logic [5:0] S_WIN_END  = 6'd11;
	localparam logic [5:0] S_MAP_INIT = 6'd12;
	localparam logic [5:0] S_MS_CHK   = 6'd13;
	localparam logic [5:0] S_MS_RD    = 6'd14;
	localparam logic [5:0] S_MS_USE   = 6'd15;
	localparam logic [5:0] S_MV_INIT  = 6'd16;
	localparam logic [5:0] S_MV_CHK   = 6'd17;
	localparam logic [5:0] S_MV_RD    = 6'd18;
	localparam logic [5:0] S_MV_USE   = 6'd19;
	localparam logic [5:0] S_SUM_CHK  = 6'd20;
	localparam logic [5:0] S_SUM_RD   = 6'd21;
	localparam logic [5:0] S_SUM_USE  = 6'd22;
	localparam logic [5:0] S_SUM_END  = 6'd23;
	localparam logic [5:0] S_MAPV     = 6'd24;
	localparam logic [5:0] S_MAPV_RD  = 6'd25;
	localparam logic [5:0] S_MAPV_USE = 6'd26;
	localparam logic [5:0] S_BT_INIT  = 6'd27;
	localparam logic [5:0] S_BT_CHK   = 6'd28;
	localparam logic [5:0] S_BT_RD    = 6'd29;
	localparam logic [5:0] S_BT_USE   = 6'd30;
	localparam logic [5:0] S_CAT      = 6'd31;
	localparam logic [5:0] S_EMIT     = 6'd32;

	logic [5:0] state_q, state_d;
	logic       emit;

	assign in_ready = state_q == S_IDLE;
	assign emit     = (state_q == S_EMIT) & (!out_valid | out_ready);

	// Next state and datapath operation
	always_comb begin
		state_d = state_q;
		cmd.op  = obpa_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = obpa_pkg::OP_LOAD;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.op  = obpa_pkg::OP_MUL;
				state_d = S_CONV;
			end
			S_CONV: begin
				cmd.op  = obpa_pkg::OP_CONV;
				state_d = S_STEP;
			end
			S_STEP: begin
				cmd.op  = obpa_pkg::OP_STEP;
				state_d = st.analyze ? S_SYS_INIT : S_EMIT;
			end
			S_SYS_INIT: begin
				cmd.op  = obpa_pkg::OP_SYS_INIT;
				state_d = S_SYS_CHK;
			end
			S_SYS_CHK: begin
				cmd.op  = obpa_pkg::OP_ADDR_I;
				state_d = st.i_ge_scan ? S_MAP_INIT : S_SYS_RD;
			end
			S_SYS_RD: state_d = S_SYS_USE;
			S_SYS_USE: begin
				cmd.op  = obpa_pkg::OP_SYS_USE;
				state_d = st.s_pos ? S_WIN_ADDR : S_SYS_CHK;
			end
			S_WIN_ADDR: begin
				cmd.op  = obpa_pkg::OP_ADDR_WIN;
				state_d = st.k_end ? S_WIN_END : S_WIN_RD;
			end
			S_WIN_RD: state_d = S_WIN_USE;
			S_WIN_USE: begin
				cmd.op  = obpa_pkg::OP_WIN_USE;
				state_d = S_WIN_ADDR;
			end
			S_WIN_END: begin
				cmd.op  = obpa_pkg::OP_WIN_END;
				state_d = st.cnt_ok ? S_MAP_INIT : S_SYS_CHK;
			end
			S_MAP_INIT: begin
				cmd.op  = obpa_pkg::OP_MS_INIT;
				state_d = S_MS_CHK;
			end
			S_MS_CHK: begin
				cmd.op  = obpa_pkg::OP_ADDR_I;
				state_d = st.i_ge_len ? S_MV_INIT : S_MS_RD;
			end
			S_MS_RD: state_d = S_MS_USE;
			S_MS_USE: begin
				cmd.op  = obpa_pkg::OP_MS_USE;
				state_d = st.p_gt_high ? S_MS_CHK : S_MV_INIT;
			end
			S_MV_INIT: begin
				cmd.op  = obpa_pkg::OP_MV_INIT;
				state_d = S_MV_CHK;
			end
			S_MV_CHK: begin
				cmd.op  = obpa_pkg::OP_ADDR_I;
				state_d = st.i_ge_len ? S_MAPV : S_MV_RD;
			end
			S_MV_RD: state_d = S_MV_USE;
			S_MV_USE: begin
				cmd.op = obpa_pkg::OP_MV_USE;
				priority if (!st.p_gt_low)
					state_d = S_MAPV;
				else if (st.s_pos)
					state_d = S_SUM_CHK;
				else
					state_d = S_MV_CHK;
			end
			S_SUM_CHK: begin
				cmd.op  = obpa_pkg::OP_ADDR_J;
				state_d = st.j_ge_len ? S_SUM_END : S_SUM_RD;
			end
			S_SUM_RD: state_d = S_SUM_USE;
			S_SUM_USE: begin
				cmd.op  = obpa_pkg::OP_SUM_USE;
				state_d = st.s_neg ? S_SUM_END : S_SUM_CHK;
			end
			S_SUM_END: begin
				cmd.op  = obpa_pkg::OP_SUM_END;
				state_d = S_MV_CHK;
			end
			S_MAPV: begin
				cmd.op  = obpa_pkg::OP_ADDR_BIDX;
				state_d = S_MAPV_RD;
			end
			S_MAPV_RD: state_d = S_MAPV_USE;
			S_MAPV_USE: begin
				cmd.op  = obpa_pkg::OP_MAP_TAKE;
				state_d = st.map_err ? S_EMIT : S_BT_INIT;
			end
			S_BT_INIT: begin
				cmd.op  = obpa_pkg::OP_BT_INIT;
				state_d = S_BT_CHK;
			end
			S_BT_CHK: begin
				cmd.op  = obpa_pkg::OP_ADDR_I;
				state_d = st.i_gt_end ? S_CAT : S_BT_RD;
			end
			S_BT_RD: state_d = S_BT_USE;
			S_BT_USE: begin
				cmd.op  = obpa_pkg::OP_BT_USE;
				state_d = S_BT_CHK;
			end
			S_CAT: begin
				cmd.op  = obpa_pkg::OP_CAT;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (emit) begin
					cmd.op  = obpa_pkg::OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Hold the result valid until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (emit)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

endmodule

@@ sv/oscillometric_bp_analyzer_core.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// oscillometric_bp_analyzer_core: oscillometric blood-pressure analyzer
//
//   channel  | dir | transaction payload
//   ---------+-----+------------------------------------------------------------
//   sample   | in  | action, sensor_count
//   result   | out | pressure, rate_status, done_res, systolic, diastolic,
//            |     | heart_rate, category, deflate_error
//   wr_*     | in  | register write: wr_en, wr_index, wr_data
//
// A sample passes load, multiply, convert and step to a result held in the
// output register. A sample that ends the record then walks the record memories
// through a shared read address; the MAP rise-sum search is quadratic in the
// record length. Reset clears control state; stored samples are not cleared.
// A new sample is taken while a result waits; the next result waits for it.
// -----------------------------------------------------------------------------
module oscillometric_bp_analyzer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	obpa_sample_if.sink                     sample,
	obpa_result_if.source                   result,
	input  logic                            wr_en,
	input  logic [obpa_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [obpa_pkg::CFG_DATA_W-1:0] wr_data
);

	obpa_pkg::cmd_t    cmd;
	obpa_pkg::status_t st;

	// Sequencer
	obpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath and record memories
	obpa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.action        (sample.action),
		.sensor_count  (sample.sensor_count),
		.pressure      (result.pressure),
		.rate_status   (result.rate_status),
		.done_res      (result.done_res),
		.systolic      (result.systolic),
		.diastolic     (result.diastolic),
		.heart_rate    (result.heart_rate),
		.category      (result.category),
		.deflate_error (result.deflate_error)
	);

endmodule

@@ sv/obpa_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// obpa_checker: port-level checks for the analyzer
// Watches the channels and flags result combinations the block never gives.
// -----------------------------------------------------------------------------
module obpa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [obpa_pkg::P_W-1:0]          pressure,
	input logic [obpa_pkg::RATE_W-1:0]       rate_status,
	input logic                              done_res,
	input logic [obpa_pkg::SYS_W-1:0]        systolic,
	input logic signed [obpa_pkg::DIA_W-1:0] diastolic,
	input logic [obpa_pkg::HR_W-1:0]         heart_rate,
	input logic [obpa_pkg::CAT_W-1:0]        category,
	input logic                              deflate_error
);

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure) &&
		$stable(systolic) && $stable(diastolic) && $stable(category))
		else $error("result changed while stalled");

	// One sample at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while busy");

	// Analysis fields are zero unless the record ended
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> systolic == '0 && diastolic == '0 &&
		heart_rate == '0 && category == obpa_pkg::CAT_NORMAL && !deflate_error)
		else $error("analysis fields set without end of record");

	// A MAP error clears the analysis fields
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && deflate_error |-> done_res && systolic == '0 &&
		diastolic == '0 && heart_rate == '0)
		else $error("fields set with MAP error");

	// Codes stay in range
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rate_status != 2'd3 && category <= obpa_pkg::CAT_STAGE3)
		else $error("code out of range");

endmodule

bind oscillometric_bp_analyzer_core obpa_checker u_obpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (sample.valid),
	.in_ready      (sample.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.pressure      (result.pressure),
	.rate_status   (result.rate_status),
	.done_res      (result.done_res),
	.systolic      (result.systolic),
	.diastolic     (result.diastolic),
	.heart_rate    (result.heart_rate),
	.category      (result.category),
	.deflate_error (result.deflate_error)
);

@@ sim/tb_oscillometric_bp_analyzer_core.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_oscillometric_bp_analyzer_core: self-checking bench for the BP analyzer
// Feeds deflation records (reference sample, oscillating descent, stop sample)
// mixed with stray samples, predicts every result in a scoreboard class and
// compares each result transaction field by field, over several register sets
// and several idle/stall mixes.
// -----------------------------------------------------------------------------
module tb_oscillometric_bp_analyzer_core;
	import obpa_pkg::*;

	localparam int  DEPTH      = 2048;
	localparam int  SCAN       = 1024;
	localparam int  RISE_WIN   = 20;
	localparam int  BEAT_HALF  = 37;
	localparam int  MAX_CYCLES = 3000000;
	localparam logic ACT_REF   = 1'b0;
	localparam logic ACT_REC   = 1'b1;

	typedef struct packed {
		logic [P_W-1:0]          pressure;
		logic [RATE_W-1:0]       rate_status;
		logic                    done_res;
		logic [SYS_W-1:0]        systolic;
		logic signed [DIA_W-1:0] diastolic;
		logic [HR_W-1:0]         heart_rate;
		logic [CAT_W-1:0]        category;
		logic                    deflate_error;
	} bp_result_t;

	// Scoreboard: own copy of the analyzer state plus the queue of expected results
	class bp_scoreboard;
		int unsigned stop_level = 1920, fast_drop = 51, slow_drop = 13;
		int unsigned min_rises = 4, map_low = 5120, map_high = 8320;
		int unsigned p_mem[DEPTH];
		int          s_mem[DEPTH];
		int unsigned prev_p, rec_len;
		bit          active;
		bp_result_t  pending[$];
		int          mismatches, checked, records;

		function int unsigned pressure_of(logic [COUNT_W-1:0] cnt);
			longint unsigned num;
			longint unsigned v;
			num = longint'(cnt) * 96000;
			if (num <= 64'd40265318400)
				return 0;
			v = (num - 64'd40265318400) >> 24;
			return (v > 32767) ? 32767 : int'(v);
		endfunction

		function int unsigned systolic_of(int unsigned len);
			int unsigned lim, cnt, j;
			lim = (len < SCAN) ? len : SCAN;
			for (int unsigned i = 0; i < lim; i++) begin
				if (s_mem[i] > 0) begin
					cnt = 0;
					for (int unsigned k = 0; k < RISE_WIN; k++) begin
						j = i + k;
						if (j >= len)
							j = len - 1;
						if (s_mem[j] > 0)
							cnt++;
					end
					if (cnt > min_rises)
						return p_mem[i];
				end
			end
			return 0;
		endfunction

		function int unsigned map_index_of(int unsigned len);
			int unsigned first, j, best_idx;
			longint best, sum;
			first = 0;
			best_idx = 0;
			best = 0;
			for (int unsigned i = 1; i < len && p_mem[i] > map_high; i++)
				first = i;
			for (int unsigned i = first; i < len && p_mem[i] > map_low; i++) begin
				if (s_mem[i] > 0) begin
					sum = 0;
					for (j = i + 1; j < len && s_mem[j] >= 0; j++)
						sum += s_mem[j];
					if (sum > best) begin
						best = sum;
						best_idx = (j < len) ? j : len - 1;
					end
				end
			end
			return best_idx;
		endfunction

		function int unsigned beat_rate_of(int unsigned m, int unsigned len);
			int cnt;
			cnt = 0;
			for (int i = int'(m) - BEAT_HALF; i <= int'(m) + BEAT_HALF; i++)
				if (i >= 0 && i + 1 < int'(len) && s_mem[i] > 0 && s_mem[i+1] < 0)
					cnt++;
			return (cnt * 4 > 511) ? 511 : cnt * 4;
		endfunction

		function logic [CAT_W-1:0] category_of(int sys, int dia);
			if (sys < 120*64 && dia < 80*64)
				return CAT_NORMAL;
			if (sys >= 120*64 && sys < 130*64 && dia < 80*64)
				return CAT_ELEVATED;
			if ((sys >= 130*64 && sys < 140*64) || (dia >= 80*64 && dia < 90*64))
				return CAT_STAGE1;
			if ((sys >= 140*64 && sys < 180*64) || (dia >= 90*64 && dia < 120*64))
				return CAT_STAGE2;
			return CAT_STAGE3;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
			case (idx)
				REG_STOP_LEVEL: stop_level = v & 32'h7FFF;
				REG_FAST_DROP:  fast_drop  = v & 32'h7FFF;
				REG_SLOW_DROP:  slow_drop  = v & 32'h7FFF;
				REG_MIN_RISES:  min_rises  = v & 32'h3F;
				REG_MAP_LOW:    map_low    = v & 32'h7FFF;
				REG_MAP_HIGH:   map_high   = v & 32'h7FFF;
				default: ;
			endcase
		endfunction

		// Predict the result of one accepted sample
		function void note_sample(logic act, logic [COUNT_W-1:0] cnt);
			bp_result_t e;
			int unsigned p, sys, mi, mapv;
			int d, dia;
			e = '0;
			p = pressure_of(cnt);
			e.pressure = p[P_W-1:0];
			if (act == ACT_REF) begin
				prev_p = p;
				rec_len = 0;
				active = 1;
			end else if (active) begin
				d = int'(p) - int'(prev_p);
				if (d < -int'(fast_drop))
					e.rate_status = RATE_FAST;
				else if (d > -int'(slow_drop) && d < 0)
					e.rate_status = RATE_SLOW;
				else
					e.rate_status = RATE_STEADY;
				if (rec_len < DEPTH) begin
					p_mem[rec_len] = p;
					s_mem[rec_len] = d;
					rec_len++;
				end
				prev_p = p;
				if (p <= stop_level || rec_len >= DEPTH) begin
					active = 0;
					records++;
					e.done_res = 1;
					sys = systolic_of(rec_len);
					mi = map_index_of(rec_len);
					mapv = p_mem[mi];
					if (mapv > map_high || mapv < map_low) begin
						e.deflate_error = 1;
					end else begin
						dia = 2 * int'(mapv) - int'(sys);
						e.systolic = sys[SYS_W-1:0];
						e.diastolic = (dia > 32767) ? 16'sh7FFF : dia[DIA_W-1:0];
						e.heart_rate = HR_W'(beat_rate_of(mi, rec_len));
						e.category = category_of(int'(sys), dia);
					end
				end
			end
			pending.push_back(e);
		endfunction

		// Compare one result transaction with the oldest prediction
		function void check_result(bp_result_t got);
			bp_result_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", got);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch on result %0d", checked);
					$display("  expected %p", e);
					$display("  actual   %p", got);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	obpa_sample_if smp();
	obpa_result_if res();

	oscillometric_bp_analyzer_core dut (
		.clk(clk), .arst_n(arst_n), .sample(smp), .result(res),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	bp_scoreboard sb = new();
	int  idle_pct;
	int  stall_pct;
	int  hold_req;
	int  hold_left;
	int  cycles;
	int  sent;

	// Clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Drive ready: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check every result transaction
	always @(posedge clk) begin
		bp_result_t got;
		if (arst_n && res.valid && res.ready) begin
			got.pressure      = res.pressure;
			got.rate_status   = res.rate_status;
			got.done_res      = res.done_res;
			got.systolic      = res.systolic;
			got.diastolic     = res.diastolic;
			got.heart_rate    = res.heart_rate;
			got.category      = res.category;
			got.deflate_error = res.deflate_error;
			sb.check_result(got);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Sensor count that converts to the given pressure
	function automatic logic [COUNT_W-1:0] count_for(int p);
		longint unsigned v;
		if (p <= 0)
			return COUNT_W'($urandom_range(419430));
		if (p > 32767)
			p = 32767;
		v = ((longint'(p) << 24) + 64'd40265318400 + 95999) / 96000;
		return v[COUNT_W-1:0];
	endfunction

	// Offer one sample and hold it until the transaction completes
	task automatic send_sample(logic act, logic [COUNT_W-1:0] cnt);
		while ($urandom_range(99) < idle_pct) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.action <= act;
		smp.sensor_count <= cnt;
		do
			@(posedge clk);
		while (!smp.ready);
		sb.note_sample(act, cnt);
		sent++;
	endtask

	// Drop valid and wait until every predicted result has arrived
	task automatic drain();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// Write one register with the block idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
		drain();
		repeat (8) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v[CFG_DATA_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic write_all(int unsigned stop, int unsigned fast, int unsigned slow,
		int unsigned rises, int unsigned lo, int unsigned hi);
		write_reg(REG_STOP_LEVEL, stop);
		write_reg(REG_FAST_DROP, fast);
		write_reg(REG_SLOW_DROP, slow);
		write_reg(REG_MIN_RISES, rises);
		write_reg(REG_MAP_LOW, lo);
		write_reg(REG_MAP_HIGH, hi);
	endtask

	// One deflation record: reference, descent with pulse ripple, stop sample
	task automatic send_record(int len, int top);
		int base, step, amp, period, p, stop;
		stop = int'(sb.stop_level);
		step = (top - stop) / (len + 1);
		amp = $urandom_range(400);
		period = $urandom_range(8, 3);
		base = top;
		send_sample(ACT_REF, count_for(top));
		for (int n = 1; n < len; n++) begin
			base -= step + $urandom_range(20) - 10;
			p = base + (((n % period) < period / 2) ? amp * (n % period) / period : 0);
			if (p <= stop)
				p = stop + 1 + $urandom_range(30);
			send_sample(ACT_REC, count_for(p));
		end
		send_sample(ACT_REC, count_for(stop - $urandom_range(200)));
	endtask

	// Random phase: mostly well-formed records, some noise and broken records
	task automatic random_phase(int items);
		int goal, r;
		goal = sent + items;
		while (sent < goal) begin
			r = $urandom_range(99);
			if (r < 75) begin
				send_record($urandom_range(50, 6), $urandom_range(14000, 9000));
			end else if (r < 85) begin
				// abandoned record restarted by a new reference
				send_sample(ACT_REF, count_for($urandom_range(12000, 8000)));
				repeat ($urandom_range(5)) send_sample(ACT_REC, count_for($urandom_range(12000, 6000)));
			end else begin
				send_sample(1'($urandom_range(1)), COUNT_W'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		smp.valid = 1'b0;
		smp.action = ACT_REF;
		smp.sensor_count = '0;
		res.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		hold_left = 0;
		cycles = 0;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle samples, conversion extremes, rate classes
		send_sample(ACT_REC, 24'h000000);
		send_sample(ACT_REC, 24'hFFFFFF);
		send_sample(ACT_REF, 24'hFFFFFF);
		send_sample(ACT_REC, count_for(32767 - 100));
		send_sample(ACT_REC, count_for(32767 - 105));
		send_sample(ACT_REC, count_for(32767 - 105));
		send_sample(ACT_REC, count_for(32767 - 50));
		send_sample(ACT_REF, 24'd419431);
		send_sample(ACT_REF, count_for(11000));
		send_sample(ACT_REC, count_for(10500));
		send_sample(ACT_REC, 24'd0);
		send_sample(ACT_REC, count_for(5000));
		// Directed: hand-shaped record with clear pulses around MAP
		send_sample(ACT_REF, count_for(11000));
		for (int n = 0; n < 24; n++)
			send_sample(ACT_REC, count_for(10800 - n * 220 + ((n % 4 == 1) ? 300 : 0)));
		send_sample(ACT_REC, count_for(1500));

		// Full record: steady pressure that never reaches the stop level
		write_all(0, 51, 13, 4, 5120, 32767);
		send_sample(ACT_REF, count_for(20000));
		for (int n = 0; n < DEPTH; n++)
			send_sample(ACT_REC, count_for(20000));

		// Register extremes
		write_all(32767, 0, 32767, 0, 0, 32767);
		send_record(8, 12000);
		send_sample(ACT_REF, count_for(5000));
		send_sample(ACT_REC, count_for(6000));
		write_all(1920, 32767, 0, 63, 0, 0);
		send_record(20, 12000);
		write_all(1920, 51, 13, 0, 3000, 12000);
		send_record(30, 13000);

		// Random phases over several register sets and idle mixes
		write_all(1920, 51, 13, 4, 5120, 8320);
		idle_pct = 0;  stall_pct = 0;  random_phase(110);
		idle_pct = 68; stall_pct = 0;  random_phase(110);
		write_all($urandom_range(3000, 500), $urandom_range(400), $urandom_range(100),
			$urandom_range(8), $urandom_range(6000, 3000), $urandom_range(10000, 7000));
		idle_pct = 0;  stall_pct = 68; random_phase(110);
		idle_pct = 11; stall_pct = 11; random_phase(110);

		// Long receiver hold-off while samples keep coming, then a full drain
		idle_pct = 0; stall_pct = 0;
		hold_req = 400;
		send_record(40, 12000);
		drain();
		write_all(1920, 51, 13, 4, 5120, 8320);
		idle_pct = 11; stall_pct = 68; random_phase(110);

		drain();
		repeat (200) @(posedge clk);
		$display("%0d samples sent, %0d results checked, %0d records analyzed",
			sent, sb.checked, sb.records);
		$display("%0d mismatches, %0d results still expected",
			sb.mismatches, sb.pending.size());
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
